// File: src/kpc_pkg.sv
// kpc_pkg: shared constants, key and result codes, and the result struct
// for the keypad password checker. No dependencies.
package kpc_pkg;

	localparam int PASS_LEN = 5;

	// Password register width and the zero-extended width for long passwords.
	localparam int PW_W     = 40;
	localparam int PW_EXT_W = ((PASS_LEN > 5) ? PASS_LEN : 5) * 8;

	localparam int KEY_W  = 8;
	localparam int CNT_W  = 4;
	localparam int FAIL_W = 3;
	localparam int CFG_W  = 40;

	localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
	localparam logic [FAIL_W-1:0] FAIL_MAX = '1;

	localparam logic [KEY_W-1:0] KEY_ENTER  = 8'd10;
	localparam logic [KEY_W-1:0] KEY_DELETE = 8'd127;

	// Configuration register indexes.
	localparam logic CFG_PASSWORD = 1'b0;
	localparam logic CFG_MAX_FAIL = 1'b1;

	localparam logic [FAIL_W-1:0] MAX_FAIL_RESET = 3'd3;
	localparam logic [PW_W-1:0]   PASSWORD_RESET = 40'h3132333435;

	// echo_action codes
	localparam logic [1:0] ECHO_NONE  = 2'd0;
	localparam logic [1:0] ECHO_STAR  = 2'd1;
	localparam logic [1:0] ECHO_ERASE = 2'd2;

	// verdict codes
	localparam logic [1:0] VERDICT_TYPING = 2'd0;
	localparam logic [1:0] VERDICT_ACCEPT = 2'd1;
	localparam logic [1:0] VERDICT_RETRY  = 2'd2;
	localparam logic [1:0] VERDICT_LOCKED = 2'd3;

	typedef struct packed {
		logic [1:0] echo_action;
		logic [1:0] verdict;
		logic       finished;
	} kpc_result_t;

endpackage

// File: src/kpc_entry.sv
// kpc_entry: entry state (count, overflow, per-position match, failures,
// session end) and the per-key result logic. Uses kpc_pkg.
module kpc_entry import kpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [KEY_W-1:0]  key,
	input  logic [PW_W-1:0]   password,
	input  logic [FAIL_W-1:0] max_fail,
	output kpc_result_t       result,
	output logic              done
);

	logic [CNT_W-1:0]    count_q, count_d;
	logic                too_long_q, too_long_d;
	logic [PASS_LEN-1:0] match_q, match_d;
	logic [FAIL_W-1:0]   fail_q, fail_d, fail_inc;
	logic                done_q, done_d;
	logic [PW_EXT_W-1:0] pw_ext;
	logic                ok;

	assign pw_ext   = PW_EXT_W'(password);
	assign fail_inc = (fail_q != FAIL_MAX) ? fail_q + 1'b1 : fail_q;
	assign ok = !too_long_q && (count_q == CNT_W'(PASS_LEN)) && (&match_q);

	always_comb begin
		count_d    = count_q;
		too_long_d = too_long_q;
		match_d    = match_q;
		fail_d     = fail_q;
		done_d     = done_q;
		result     = '{echo_action: ECHO_NONE, verdict: VERDICT_TYPING, finished: done_q};
		if (!done_q) begin
			priority if (key == KEY_ENTER) begin
				count_d    = '0;
				too_long_d = 1'b0;
				match_d    = '0;
				if (ok) begin
					result.verdict = VERDICT_ACCEPT;
					done_d = 1'b1;
				end else begin
					fail_d = fail_inc;
					if (fail_inc >= max_fail) begin
						result.verdict = VERDICT_LOCKED;
						done_d = 1'b1;
					end else begin
						result.verdict = VERDICT_RETRY;
					end
				end
			end else if (key == KEY_DELETE) begin
				if (count_q != '0) begin
					count_d = count_q - 1'b1;
					result.echo_action = ECHO_ERASE;
				end
			end else begin
				result.echo_action = ECHO_STAR;
				for (int p = 0; p < PASS_LEN; p++) begin
					if (count_q == CNT_W'(p))
						match_d[p] = (key == pw_ext[8*(PASS_LEN-1-p) +: 8]);
				end
				if (count_q == CNT_MAX)
					too_long_d = 1'b1;
				else
					count_d = count_q + 1'b1;
			end
			result.finished = done_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			too_long_q <= 1'b0;
			match_q    <= '0;
			fail_q     <= '0;
			done_q     <= 1'b0;
		end else if (take) begin
			count_q    <= count_d;
			too_long_q <= too_long_d;
			match_q    <= match_d;
			fail_q     <= fail_d;
			done_q     <= done_d;
		end
	end

	assign done = done_q;

endmodule

// File: src/kpc_out_reg.sv
// kpc_out_reg: result register with valid/stall handshake toward the sink.
// Uses kpc_pkg for the result struct.
module kpc_out_reg import kpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  kpc_result_t din,
	input  logic        out_stall,
	output logic        out_valid,
	output logic        free,
	output kpc_result_t dout
);

	logic        valid_q;
	kpc_result_t data_q;

	// Free when empty or when the held result transfers this cycle.
	assign free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

	assign out_valid = valid_q;
	assign dout      = data_q;

endmodule

// File: src/keypad_password_checker.sv
// keypad_password_checker: top level of the keypad combination lock.
// Depends on kpc_pkg, kpc_entry and kpc_out_reg.

// One key code per transfer in, one result per transfer out. A key is taken
// whenever the result register is empty or its result leaves in the same
// cycle, so a key can be accepted every clock; its result appears in the cycle
// after acceptance from the single result register, while the entry state
// updates in the accept cycle. Ordinary keys echo a star, delete erases one
// star (nothing on an empty entry), and enter closes the attempt, which passes
// only if exactly PASS_LEN keys were typed, all matched the password and the
// entry never overflowed 15 keys. After a pass or max_failures rejections, the
// session is finished: every later key returns nothing with finished set. The
// user writes configuration (cfg_index 0 password, first key in the top byte;
// 1 max failures, low 3 bits) only while idle; the block does not enforce it.
module keypad_password_checker import kpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// configuration writes
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	// key input channel
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [KEY_W-1:0] key_code,
	// result channel
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       echo_action,
	output logic [1:0]       verdict,
	output logic             finished
);

	logic [PW_W-1:0]   password_q;
	logic [FAIL_W-1:0] max_fail_q;
	logic              free;
	logic              take;
	logic              done;
	kpc_result_t       result;
	kpc_result_t       held;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			password_q <= PASSWORD_RESET;
			max_fail_q <= MAX_FAIL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PASSWORD: password_q <= cfg_data[PW_W-1:0];
				CFG_MAX_FAIL: max_fail_q <= cfg_data[FAIL_W-1:0];
				default:      ;
			endcase
		end
	end

	// Input transfer whenever the result register can take the outcome.
	assign in_stall = !free;
	assign take     = in_valid && free;

	kpc_entry u_entry (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.key      (key_code),
		.password (password_q),
		.max_fail (max_fail_q),
		.result   (result),
		.done     (done)
	);

	kpc_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.din       (result),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.free      (free),
		.dout      (held)
	);

	assign echo_action = held.echo_action;
	assign verdict     = held.verdict;
	assign finished    = held.finished;

	// Session end is sticky.
	assert property (@(posedge clk) disable iff (!arst_n) done |=> done)
		else $error("session end cleared");

	// A finished session never echoes.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && finished) |-> (echo_action == ECHO_NONE))
		else $error("echo after session end");

	// A retry verdict never ends the session.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && verdict == VERDICT_RETRY) |-> !finished)
		else $error("retry with finished set");

	// Input is only held off by a waiting result.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without backpressure");

endmodule
